// ===== rtl/fcr_pkg.sv =====
// Shared widths, codes, defaults and structs of the framed command receiver.
package fcr_pkg;

    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int SUM_W      = 16;
    localparam int EV_W       = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    // Result events
    localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EV_W-1:0] EV_ACCEPT   = 3'd1;
    localparam logic [EV_W-1:0] EV_MISMATCH = 3'd2;
    localparam logic [EV_W-1:0] EV_TIMEOUT  = 3'd3;
    localparam logic [EV_W-1:0] EV_READ     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC1   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC2   = 8'd3;

    // Configuration defaults
    localparam logic [SUM_W-1:0]  SEED_RST    = 16'hAB34;
    localparam logic [BYTE_W-1:0] TIMEOUT_RST = 8'd10;
    localparam logic [BYTE_W-1:0] SYNC1_RST   = 8'd65;
    localparam logic [BYTE_W-1:0] SYNC2_RST   = 8'd84;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] read_index;
    } t_item;

    typedef struct packed {
        logic [SUM_W-1:0]  seed;
        logic [BYTE_W-1:0] timeout;
        logic [BYTE_W-1:0] first_sync;
        logic [BYTE_W-1:0] second_sync;
    } t_cfg;

    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
    } t_parse_res;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_store_wr;

endpackage

// ===== rtl/fcr_in_if.sv =====
// Input item channel: byte, tick or payload read request.
interface fcr_in_if;
    logic                                valid;
    logic                                ready;
    logic [fcr_pkg::KIND_W-1:0]          kind;
    logic [fcr_pkg::BYTE_W-1:0]          rx_byte;
    logic [fcr_pkg::BYTE_W-1:0]          read_index;

    modport source (output valid, kind, rx_byte, read_index, input ready);
    modport sink   (input valid, kind, rx_byte, read_index, output ready);
endinterface

// ===== rtl/fcr_out_if.sv =====
// Result item channel: event, frame header fields and read data.
interface fcr_out_if;
    logic                                valid;
    logic                                ready;
    logic [fcr_pkg::EV_W-1:0]            event_res;
    logic [fcr_pkg::BYTE_W-1:0]          command;
    logic [fcr_pkg::BYTE_W-1:0]          length;
    logic [fcr_pkg::BYTE_W-1:0]          read_data;

    modport source (output valid, event_res, command, length, read_data, input ready);
    modport sink   (input valid, event_res, command, length, read_data, output ready);
endinterface

// ===== rtl/fcr_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface fcr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [fcr_pkg::CFG_IDX_W-1:0]       index;
    logic [fcr_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fcr_parser.sv =====
// Frame parser: phase machine, running checksum, idle counter, store write request.
module fcr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  fcr_pkg::t_item      i_item,
    input  fcr_pkg::t_cfg       i_cfg,
    output fcr_pkg::t_parse_res o_res,
    output fcr_pkg::t_store_wr  o_wr
);
    import fcr_pkg::*;

    // Phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_SUMHI = 3'd5;
    localparam logic [2:0] PH_SUMLO = 3'd6;

    logic [2:0]        r_phase,   n_phase;
    logic [BYTE_W-1:0] r_command, n_command;
    logic [BYTE_W-1:0] r_length,  n_length;
    logic [BYTE_W-1:0] r_pos,     n_pos;
    logic [SUM_W-1:0]  r_sum,     n_sum;
    logic [BYTE_W-1:0] r_sum_hi,  n_sum_hi;
    logic [BYTE_W-1:0] r_idle,    n_idle;
    logic [BYTE_W-1:0] idle_inc;
    logic [EV_W-1:0]   ev;
    logic [BYTE_W-1:0] b;

    assign b = i_item.rx_byte;
    // saturating tick count
    assign idle_inc = (r_idle == '1) ? r_idle : r_idle + 8'd1;

    // Next state for one item
    always_comb begin
        n_phase   = r_phase;
        n_command = r_command;
        n_length  = r_length;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_sum_hi  = r_sum_hi;
        n_idle    = r_idle;
        ev        = EV_NONE;
        o_wr.en   = 1'b0;
        o_wr.addr = r_pos;
        o_wr.data = b;
        case (i_item.kind)
            KIND_BYTE: begin
                n_idle = '0;
                case (r_phase)
                    PH_SYNC2: begin
                        n_phase = (b == i_cfg.second_sync) ? PH_CMD : PH_IDLE;
                    end
                    PH_CMD: begin
                        n_command = b;
                        n_sum     = i_cfg.seed + SUM_W'(b);
                        n_phase   = PH_LEN;
                    end
                    PH_LEN: begin
                        n_length = b;
                        n_sum    = r_sum + SUM_W'(b);
                        n_pos    = '0;
                        n_phase  = (b == '0) ? PH_SUMHI : PH_DATA;
                    end
                    PH_DATA: begin
                        n_sum   = r_sum + SUM_W'(b);
                        o_wr.en = 1'b1;
                        n_pos   = r_pos + 8'd1;
                        if (n_pos == r_length) begin
                            n_phase = PH_SUMHI;
                        end
                    end
                    PH_SUMHI: begin
                        n_sum_hi = b;
                        n_phase  = PH_SUMLO;
                    end
                    PH_SUMLO: begin
                        ev      = (r_sum == {r_sum_hi, b}) ? EV_ACCEPT : EV_MISMATCH;
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = (b == i_cfg.first_sync) ? PH_SYNC2 : PH_IDLE;
                    end
                endcase
            end
            KIND_TICK: begin
                if (r_phase == PH_IDLE || r_phase > PH_SUMLO) begin
                    n_phase = PH_IDLE;
                    n_idle  = '0;
                end else if (idle_inc >= i_cfg.timeout) begin
                    n_phase = PH_IDLE;
                    n_idle  = '0;
                    ev      = EV_TIMEOUT;
                end else begin
                    n_idle = idle_inc;
                end
            end
            KIND_READ: begin
                ev = EV_READ;
            end
            default: begin
                ev = EV_NONE;
            end
        endcase
        // the write request is only acted on when the item really moves on
        o_wr.en = o_wr.en & i_en;
    end

    assign o_res.ev      = ev;
    assign o_res.command = n_command;
    assign o_res.length  = n_length;

    // State registers advance once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_command <= '0;
            r_length  <= '0;
            r_pos     <= '0;
            r_sum     <= '0;
            r_sum_hi  <= '0;
            r_idle    <= '0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_command <= n_command;
            r_length  <= n_length;
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_sum_hi  <= n_sum_hi;
            r_idle    <= n_idle;
        end
    end

endmodule

// ===== rtl/fcr_payload_ram.sv =====
// Payload store: one write port, one registered read port; out-of-range reads give zero.
module fcr_payload_ram #(
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  fcr_pkg::t_store_wr         i_wr,
    input  logic                       i_rd_en,
    input  logic                       i_rd_req,
    input  logic [fcr_pkg::BYTE_W-1:0] i_rd_addr,
    output logic [fcr_pkg::BYTE_W-1:0] o_rd_data
);
    import fcr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic              wr_in_range;
    logic              rd_in_range;

    assign wr_in_range = {1'b0, i_wr.addr} < (BYTE_W + 1)'(DEPTH);
    assign rd_in_range = {1'b0, i_rd_addr} < (BYTE_W + 1)'(DEPTH);

    // Write port: bytes past the end are dropped
    always_ff @(posedge i_clk) begin
        if (i_wr.en && wr_in_range) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
    end

    // Read port: registered, zero for non-read items and out-of-range indexes
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_rd_req && rd_in_range) begin
                r_rd_data <= r_mem[i_rd_addr[AW-1:0]];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/framed_command_receiver.sv =====
// Top level of the framed command receiver: item register, parser, store, result register.
//
//  Port     Dir   Handshake      Carries
//  i_cmd    in    valid/ready    kind, rx_byte, read_index
//  o_res    out   valid/ready    event_res, command, length, read_data
//  i_cfg    in    valid/ready    index, data (ready always high)
//
// One item per cycle sustained while results are taken; an accepted item passes
// the input register, then the result register and store read, where its result
// is valid.
// Reset (i_rst_n low, synchronous) clears the parser, the config registers to
// their defaults and both stage valids; the payload store is not cleared.
// A stalled result holds the result register and the item behind it; input
// ready drops only when both stages are full and the result is not taken.
module framed_command_receiver #(
    parameter int PAYLOAD_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcr_in_if.sink    i_cmd,
    fcr_out_if.source o_res,
    fcr_cfg_if.sink   i_cfg
);
    import fcr_pkg::*;

    logic       r_s1_valid;
    t_item      r_s1_item;
    logic       r_out_valid;
    t_parse_res r_out;
    t_cfg       r_cfg;
    t_parse_res parse_res;
    t_store_wr  store_wr;
    logic       out_free;
    logic       s1_go;
    logic       in_take;

    // Pipeline flow
    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_go       = r_s1_valid && out_free;
    assign i_cmd.ready = !r_s1_valid || s1_go;
    assign in_take     = i_cmd.valid && i_cmd.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_s1_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item.kind       <= i_cmd.kind;
            r_s1_item.rx_byte    <= i_cmd.rx_byte;
            r_s1_item.read_index <= i_cmd.read_index;
        end
    end

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed        <= SEED_RST;
            r_cfg.timeout     <= TIMEOUT_RST;
            r_cfg.first_sync  <= SYNC1_RST;
            r_cfg.second_sync <= SYNC2_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SEED:    r_cfg.seed        <= i_cfg.data;
                CFG_TIMEOUT: r_cfg.timeout     <= i_cfg.data[BYTE_W-1:0];
                CFG_SYNC1:   r_cfg.first_sync  <= i_cfg.data[BYTE_W-1:0];
                CFG_SYNC2:   r_cfg.second_sync <= i_cfg.data[BYTE_W-1:0];
                default:     r_cfg             <= r_cfg;
            endcase
        end
    end

    fcr_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s1_go),
        .i_item  (r_s1_item),
        .i_cfg   (r_cfg),
        .o_res   (parse_res),
        .o_wr    (store_wr)
    );

    fcr_payload_ram #(
        .DEPTH (PAYLOAD_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_en   (s1_go),
        .i_rd_req  (r_s1_item.kind == KIND_READ),
        .i_rd_addr (r_s1_item.read_index),
        .o_rd_data (o_res.read_data)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out <= parse_res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.event_res = r_out.ev;
    assign o_res.command   = r_out.command;
    assign o_res.length    = r_out.length;

`ifndef SYNTHESIS
    // A result appears only for an item that sat in the input register
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result without a pending item");

    // An item that moves on always lands in the result register
    a_s1_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> r_out_valid)
        else $error("item lost between stages");

    // Store data only shows on read results
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.event_res != EV_READ) |-> (o_res.read_data == '0))
        else $error("read data on a non-read result");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the framed command receiver: frame, tick and read traffic.
`timescale 1ns / 1ps

module testbench;
    import fcr_pkg::*;

    localparam int STORE_DEPTH      = 256;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int MAX_REPORTS      = 10;

    // Kind code outside the defined set, and a register index outside the map
    localparam logic [KIND_W-1:0]    KIND_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd4;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SYNC2, PH_CMD, PH_LEN, PH_DATA, PH_SUMHI, PH_SUMLO
    } t_phase;

    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] read_data;
    } t_parser_event;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Testbench-side drive registers
    logic                  cmd_valid = 1'b0;
    logic [KIND_W-1:0]     cmd_kind  = KIND_BYTE;
    logic [BYTE_W-1:0]     cmd_rx    = '0;
    logic [BYTE_W-1:0]     cmd_idx   = '0;
    logic                  res_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    fcr_in_if  cmd_if ();
    fcr_out_if res_if ();
    fcr_cfg_if cfg_if ();

    assign cmd_if.valid      = cmd_valid;
    assign cmd_if.kind       = cmd_kind;
    assign cmd_if.rx_byte    = cmd_rx;
    assign cmd_if.read_index = cmd_idx;
    assign res_if.ready      = res_ready;
    assign cfg_if.valid      = cfg_valid;
    assign cfg_if.index      = cfg_index;
    assign cfg_if.data       = cfg_data;

    framed_command_receiver #(.PAYLOAD_DEPTH(STORE_DEPTH)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the parser state and configuration
    t_cfg              sh_cfg = '{seed: SEED_RST, timeout: TIMEOUT_RST,
                                  first_sync: SYNC1_RST, second_sync: SYNC2_RST};
    t_phase            sh_phase  = PH_IDLE;
    logic [BYTE_W-1:0] sh_cmd    = '0;
    logic [BYTE_W-1:0] sh_len    = '0;
    logic [BYTE_W-1:0] sh_pos    = '0;
    logic [SUM_W-1:0]  sh_sum    = '0;
    logic [BYTE_W-1:0] sh_sum_hi = '0;
    logic [BYTE_W-1:0] sh_idle   = '0;
    logic [BYTE_W-1:0] sh_store [0:STORE_DEPTH-1];

    t_item         cmd_items_q[$];
    t_parser_event parser_events_q[$];

    int  items_queued = 0;
    int  cmd_offered  = 0;
    int  cmd_taken    = 0;
    int  cfg_writes   = 0;
    int  mismatches   = 0;
    int  stuck_cycles = 0;
    int  idle_pct     = 0;
    int  send_gap     = 0;
    int  stall_left   = 0;
    int  hold_reqs    = 0;
    int  holds_served = 0;
    bit  reads_ok     = 1'b0;

    // Advance the shadow parser by one accepted item and queue its result
    task automatic advance_parser(input t_item it);
        t_parser_event e;
        logic [BYTE_W-1:0] b;
        b = it.rx_byte;
        e.ev = EV_NONE;
        e.read_data = '0;
        case (it.kind)
            KIND_BYTE: begin
                sh_idle = '0;
                case (sh_phase)
                    PH_SYNC2: sh_phase = (b == sh_cfg.second_sync) ? PH_CMD : PH_IDLE;
                    PH_CMD: begin
                        sh_cmd   = b;
                        sh_sum   = sh_cfg.seed + SUM_W'(b);
                        sh_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        sh_len   = b;
                        sh_sum   = sh_sum + SUM_W'(b);
                        sh_pos   = '0;
                        sh_phase = (b == '0) ? PH_SUMHI : PH_DATA;
                    end
                    PH_DATA: begin
                        sh_sum = sh_sum + SUM_W'(b);
                        sh_store[sh_pos] = b;
                        sh_pos = sh_pos + 1'b1;
                        if (sh_pos == sh_len) sh_phase = PH_SUMHI;
                    end
                    PH_SUMHI: begin
                        sh_sum_hi = b;
                        sh_phase  = PH_SUMLO;
                    end
                    PH_SUMLO: begin
                        e.ev = (sh_sum == {sh_sum_hi, b}) ? EV_ACCEPT : EV_MISMATCH;
                        sh_phase = PH_IDLE;
                    end
                    default: sh_phase = (b == sh_cfg.first_sync) ? PH_SYNC2 : PH_IDLE;
                endcase
            end
            KIND_TICK: begin
                if (sh_phase == PH_IDLE) begin
                    sh_idle = '0;
                end else begin
                    if (sh_idle != 8'hFF) sh_idle = sh_idle + 1'b1;
                    if (sh_idle >= sh_cfg.timeout) begin
                        sh_phase = PH_IDLE;
                        sh_idle  = '0;
                        e.ev     = EV_TIMEOUT;
                    end
                end
            end
            KIND_READ: begin
                e.ev = EV_READ;
                e.read_data = sh_store[it.read_index];
            end
            default: ;
        endcase
        e.command = sh_cmd;
        e.length  = sh_len;
        parser_events_q.push_back(e);
    endtask

    // Stimulus helpers
    task automatic push_item(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
                             input logic [BYTE_W-1:0] ix);
        cmd_items_q.push_back('{kind: k, rx_byte: b, read_index: ix});
        items_queued++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        push_item(KIND_BYTE, b, BYTE_W'($urandom));
    endtask

    task automatic push_tick();
        push_item(KIND_TICK, BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    // Only entries 0..254 are ever written, so reads stay within them
    task automatic push_read(input logic [BYTE_W-1:0] ix);
        push_item(KIND_READ, BYTE_W'($urandom), ix);
    endtask

    // Ticks short of the timeout, and sometimes a read, between frame bytes
    task automatic push_gap_filler(input bit enable);
        int lim;
        lim = int'(sh_cfg.timeout) - 1;
        if (lim > 3) lim = 3;
        if (enable) begin
            if (lim > 0) repeat ($urandom_range(lim)) push_tick();
            if (reads_ok && $urandom_range(3) == 0) push_read(BYTE_W'($urandom_range(254)));
        end
    endtask

    task automatic push_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] len,
                              input bit bad_sum, input bit gaps);
        logic [SUM_W-1:0]  sum;
        logic [BYTE_W-1:0] b;
        sum = sh_cfg.seed + SUM_W'(cmd) + SUM_W'(len);
        push_byte(sh_cfg.first_sync);
        push_gap_filler(gaps);
        push_byte(sh_cfg.second_sync);
        push_gap_filler(gaps);
        push_byte(cmd);
        push_gap_filler(gaps);
        push_byte(len);
        for (int k = 0; k < int'(len); k++) begin
            b = BYTE_W'($urandom);
            sum = sum + SUM_W'(b);
            push_gap_filler(gaps);
            push_byte(b);
        end
        if (bad_sum) sum = sum ^ (SUM_W'(1) << $urandom_range(SUM_W - 1));
        push_gap_filler(gaps);
        push_byte(sum[SUM_W-1:BYTE_W]);
        push_gap_filler(gaps);
        push_byte(sum[BYTE_W-1:0]);
    endtask

    // Frame cut off partway, then left to time out
    task automatic push_abandoned_frame(input int n_ticks);
        int len;
        push_byte(sh_cfg.first_sync);
        push_byte(sh_cfg.second_sync);
        push_byte(BYTE_W'($urandom));
        if ($urandom_range(1)) begin
            len = $urandom_range(1, 8);
            push_byte(BYTE_W'(len));
            repeat ($urandom_range(len - 1)) push_byte(BYTE_W'($urandom));
        end
        repeat (n_ticks) push_tick();
    endtask

    // Mostly good frames, the rest broken frames and loose items
    task automatic push_random_traffic(input int n);
        int               stop_at;
        int               pick;
        logic [BYTE_W-1:0] len;
        stop_at = items_queued + n;
        while (items_queued < stop_at) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? BYTE_W'($urandom_range(9, 24))
                                            : BYTE_W'($urandom_range(8));
            if (pick < 55) begin
                push_frame(BYTE_W'($urandom), len, 1'b0, 1'($urandom_range(1)));
            end else if (pick < 62) begin
                push_frame(BYTE_W'($urandom), len, 1'b1, 1'($urandom_range(1)));
            end else if (pick < 67) begin
                push_byte(sh_cfg.first_sync);
                push_byte(sh_cfg.second_sync ^ BYTE_W'($urandom_range(1, 255)));
            end else if (pick < 72 && sh_cfg.timeout <= 16) begin
                push_abandoned_frame((sh_cfg.timeout == '0) ? 1 : int'(sh_cfg.timeout));
            end else begin
                case ($urandom_range(3))
                    0: push_byte(BYTE_W'($urandom));
                    1: push_tick();
                    2: push_read(BYTE_W'($urandom_range(254)));
                    default: push_item(KIND_UNUSED, BYTE_W'($urandom), BYTE_W'($urandom));
                endcase
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        int n;
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        n = cfg_writes;
        do @(negedge i_clk); while (cfg_writes == n);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued item is taken and every result has arrived
    task automatic drain();
        while (cmd_items_q.size() != 0 || cmd_offered != cmd_taken ||
               parser_events_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [SUM_W-1:0] seed, input logic [BYTE_W-1:0] tmo,
                             input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                             input int n, input int pct, input bit long_hold);
        write_reg(CFG_SEED, seed);
        write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
        write_reg(CFG_SYNC1, CFG_DATA_W'(s1));
        write_reg(CFG_SYNC2, CFG_DATA_W'(s2));
        idle_pct = pct;
        if (long_hold) hold_reqs++;
        push_random_traffic(n);
        drain();
    endtask

    // Item driver: next item on the falling edge once the previous one is taken
    always @(negedge i_clk) begin : cmd_driver
        t_item nxt;
        if (i_rst_n && cmd_offered == cmd_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                cmd_valid <= 1'b0;
            end else if (cmd_items_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = cmd_items_q.pop_front();
                cmd_valid <= 1'b1;
                cmd_kind  <= nxt.kind;
                cmd_rx    <= nxt.rx_byte;
                cmd_idx   <= nxt.read_index;
                cmd_offered++;
            end else begin
                if (cmd_items_q.size() != 0) send_gap = $urandom_range(6);
                cmd_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall bursts plus the requested long hold-off
    always @(negedge i_clk) begin : res_receiver
        if (hold_reqs != holds_served) begin
            holds_served++;
            stall_left = LONG_HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            res_ready <= 1'b0;
        end else if ($urandom_range(99) < idle_pct) begin
            stall_left = $urandom_range(6);
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    // Handshake monitor: config shadow, prediction, result check, watchdog
    always @(posedge i_clk) begin : monitor
        t_item         it;
        t_parser_event got;
        t_parser_event want;
        bit            moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_SEED:    sh_cfg.seed        = cfg_if.data;
                    CFG_TIMEOUT: sh_cfg.timeout     = cfg_if.data[BYTE_W-1:0];
                    CFG_SYNC1:   sh_cfg.first_sync  = cfg_if.data[BYTE_W-1:0];
                    CFG_SYNC2:   sh_cfg.second_sync = cfg_if.data[BYTE_W-1:0];
                    default: ;
                endcase
                cfg_writes++;
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                got = '{ev: res_if.event_res, command: res_if.command,
                        length: res_if.length, read_data: res_if.read_data};
                if (parser_events_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: ev=%0d cmd=%0h len=%0d data=%0h",
                                 got.ev, got.command, got.length, got.read_data);
                end else begin
                    want = parser_events_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("result error: expected ev=%0d cmd=%0h len=%0d data=%0h, %s",
                                     want.ev, want.command, want.length, want.read_data,
                                     $sformatf("got ev=%0d cmd=%0h len=%0d data=%0h",
                                               got.ev, got.command, got.length,
                                               got.read_data));
                    end
                end
                moved = 1'b1;
            end
            if (cmd_if.valid && cmd_if.ready) begin
                it = '{kind: cmd_if.kind, rx_byte: cmd_if.rx_byte,
                       read_index: cmd_if.read_index};
                advance_parser(it);
                cmd_taken++;
                moved = 1'b1;
            end
            if (moved) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // Test sequence
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 20;

        // Loose bytes at the byte extremes, idle tick, unused kind
        push_byte(8'h00);
        push_byte(8'hFF);
        push_tick();
        push_item(KIND_UNUSED, 8'hFF, 8'hFF);
        // Wrong second sync: back to idle, the repeated first sync does not reopen
        push_byte(sh_cfg.first_sync);
        push_byte(sh_cfg.first_sync);
        push_byte(sh_cfg.second_sync);
        // Zero length frame, then a bad checksum
        push_frame(8'hFF, 8'd0, 1'b0, 1'b0);
        push_frame(8'h00, 8'd2, 1'b1, 1'b0);
        push_read(8'd0);
        push_read(8'd1);
        drain();

        // Zero timeout aborts on the first tick of an open frame
        write_reg(CFG_SEED, 16'h0000);
        write_reg(CFG_TIMEOUT, 16'd0);
        push_tick();
        push_byte(sh_cfg.first_sync);
        push_byte(sh_cfg.second_sync);
        push_byte(8'h07);
        push_tick();
        drain();

        // Top extremes; fill store entries 0 to 254, then a frame left to time out
        write_reg(CFG_SEED, 16'hFFFF);
        write_reg(CFG_TIMEOUT, 16'd255);
        write_reg(CFG_SYNC1, 16'h0000);
        write_reg(CFG_SYNC2, 16'h00FF);
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        push_frame(BYTE_W'($urandom), 8'd255, 1'b0, 1'b0);
        push_abandoned_frame(255);
        drain();
        reads_ok = 1'b1;

        run_phase(16'($urandom), 8'd6, 8'h00, 8'hFF, 15, 10, 1'b0);
        run_phase(16'($urandom), 8'($urandom_range(2, 12)), 8'($urandom), 8'($urandom),
                  25, 15, 1'b1);
        run_phase(16'($urandom), 8'd1, 8'hFF, 8'h00, 15, 25, 1'b0);
        begin : same_sync_phase
            logic [BYTE_W-1:0] s;
            s = 8'($urandom);
            run_phase(16'($urandom), 8'($urandom_range(4, 12)), s, s, 10, 0, 1'b0);
        end
        // Last part: reset values of the timing and sync registers, no idling
        run_phase(16'($urandom), TIMEOUT_RST, SYNC1_RST, SYNC2_RST, 10, 0, 1'b0);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== framed_command_receiver.f =====
rtl/fcr_pkg.sv
rtl/fcr_in_if.sv
rtl/fcr_out_if.sv
rtl/fcr_cfg_if.sv
rtl/fcr_parser.sv
rtl/fcr_payload_ram.sv
rtl/framed_command_receiver.sv
tb/testbench.sv
